### src/rhd_pkg.sv
`default_nettype none

package rhd_pkg;

  // Default geometry
  localparam int MAX_CELLS = 64;
  localparam int TEMP_BITS = 32;

  // Fixed field widths
  localparam int GAIN_BITS    = 16;
  localparam int FRAC_BITS    = 16;
  localparam int IDX_BITS     = 6;
  localparam int VAL_BITS     = 32;
  localparam int CELLS_BITS   = 7;
  localparam int CFG_IDX_BITS = 2;
  localparam int OP_BITS      = 2;

  // Request opcodes
  localparam logic [OP_BITS-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_BITS-1:0] OP_TICK = 2'd1;
  localparam logic [OP_BITS-1:0] OP_READ = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AMBIENT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CELLS   = 2'd2;

  // Configuration reset values
  localparam logic [GAIN_BITS-1:0]         GAIN_RESET    = 16'd16384;
  localparam logic signed [VAL_BITS-1:0]   AMBIENT_RESET = 32'sd0;
  localparam logic [CELLS_BITS-1:0]        CELLS_RESET   = 7'd64;

  // One beat of the tick read stream, as seen when its data returns
  typedef struct packed {
    logic vld;      // beat carries data
    logic first;    // leftmost cell, no update yet
    logic phantom;  // beyond last used cell, right neighbor is ambient
  } beat_t;

endpackage

`default_nettype wire

### src/rhd_cell_mem.sv
`default_nettype none

// Cell store: {fixed flag, temperature} per cell, one write and one read port,
// registered read data.
module rhd_cell_mem #(
  parameter int MAX_CELLS = rhd_pkg::MAX_CELLS,
  parameter int TEMP_BITS = rhd_pkg::TEMP_BITS,
  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [TEMP_BITS:0]   wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic      [TEMP_BITS:0]   rdata
);

  logic [TEMP_BITS:0] mem [MAX_CELLS];
  logic [TEMP_BITS:0] q_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next enabled read
  always_ff @(posedge clk) begin
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  assign rdata = q_r;

endmodule

`default_nettype wire

### src/rhd_update.sv
`default_nettype none

// Tick datapath: neighbor window, laplacian, gain multiply, floor and saturate.
// Takes one beat per cycle; write-back leaves the stage 2 registers, fed through stage 1 from the right neighbor.
module rhd_update #(
  parameter int MAX_CELLS = rhd_pkg::MAX_CELLS,
  parameter int TEMP_BITS = rhd_pkg::TEMP_BITS,
  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
  localparam int CW = $clog2(MAX_CELLS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rhd_pkg::beat_t                beat,
  input  wire logic [CW-1:0]                 beat_idx,
  input  wire logic [TEMP_BITS:0]            rd_word,
  input  wire logic signed [TEMP_BITS-1:0]   amb,
  input  wire logic [rhd_pkg::GAIN_BITS-1:0] gain,
  output logic                               wr_en,
  output logic [AW-1:0]                      wr_addr,
  output logic [TEMP_BITS:0]                 wr_data,
  output logic                               busy
);

  localparam int XW = TEMP_BITS + 2;
  localparam int PW = XW + rhd_pkg::GAIN_BITS + 1;
  localparam int TW = PW - rhd_pkg::FRAC_BITS;
  localparam int SW = TEMP_BITS + 4;
  localparam logic signed [SW-1:0] SMAX =
    {{(SW - TEMP_BITS + 1){1'b0}}, {(TEMP_BITS - 1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  logic signed [TEMP_BITS-1:0] right;
  logic signed [TEMP_BITS-1:0] prev_r;
  logic signed [TEMP_BITS-1:0] cur_r;
  logic                        cur_fix_r;
  logic                        step;
  logic signed [XW-1:0]        lap;

  logic                        s1_vld_r;
  logic signed [XW-1:0]        s1_lap_r;
  logic signed [TEMP_BITS-1:0] s1_old_r;
  logic                        s1_fix_r;
  logic [AW-1:0]               s1_addr_r;

  logic signed [PW-1:0]        prod;
  logic                        s2_vld_r;
  logic signed [PW-1:0]        s2_prod_r;
  logic signed [TEMP_BITS-1:0] s2_old_r;
  logic                        s2_fix_r;
  logic [AW-1:0]               s2_addr_r;

  logic signed [TW-1:0]        term;
  logic signed [SW-1:0]        sum;
  logic signed [TEMP_BITS-1:0] new_temp;

  // right neighbor: stored cell, or ambient past the last used cell
  assign right = beat.phantom ? amb : signed'(rd_word[TEMP_BITS-1:0]);
  assign step  = beat.vld && !beat.first;

  // sliding window of left and center cell, pre-tick values
  always_ff @(posedge clk) begin
    if (beat.vld) begin
      prev_r    <= beat.first ? amb : cur_r;
      cur_r     <= right;
      cur_fix_r <= rd_word[TEMP_BITS];
    end
  end

  // stage 1: laplacian
  assign lap = XW'(prev_r) + XW'(right) - (XW'(cur_r) <<< 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_lap_r  <= lap;
      s1_old_r  <= cur_r;
      s1_fix_r  <= cur_fix_r;
      s1_addr_r <= AW'(beat_idx - 1'b1);
    end
  end

  // stage 2: k * laplacian, gain zero-extended
  assign prod = signed'({1'b0, gain}) * s1_lap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_prod_r <= prod;
      s2_old_r  <= s1_old_r;
      s2_fix_r  <= s1_fix_r;
      s2_addr_r <= s1_addr_r;
    end
  end

  // stage 3: floor by dropping fraction bits, add, saturate
  assign term = signed'(s2_prod_r[PW-1:rhd_pkg::FRAC_BITS]);
  assign sum  = SW'(s2_old_r) + SW'(term);

  always_comb begin
    if (sum > SMAX) begin
      new_temp = TEMP_BITS'(SMAX);
    end else if (sum < SMIN) begin
      new_temp = TEMP_BITS'(SMIN);
    end else begin
      new_temp = TEMP_BITS'(sum);
    end
  end

  // fixed cells pass through untouched
  assign wr_en   = s2_vld_r && !s2_fix_r;
  assign wr_addr = s2_addr_r;
  assign wr_data = {1'b0, new_temp};
  assign busy    = s1_vld_r || s2_vld_r;

endmodule

`default_nettype wire

### src/rod_heat_diffusion_step_core.sv
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_       request    in_valid/in_ready   in_opcode, in_cell_index, in_cell_value
// out_      result     out_valid/out_ready out_read_index, out_temperature, out_is_fixed
// cfg_      write      cfg_wr_en           cfg_index, cfg_wr_data
//
// Load: written to the cell memory when taken. Read: cell memory read register,
// then the output register. Tick: one cell memory read per cycle (none when
// cells_in_use is zero) through a three-stage update pipeline; requests wait
// until its write-backs finish.
// After reset a clearing pass zeroes every cell in the cell memory; no request is
// taken meanwhile. A read result waits in the output register while out_ready
// is low; loads and ticks proceed behind it.
module rod_heat_diffusion_step_core #(
  parameter int MAX_CELLS = rhd_pkg::MAX_CELLS,
  parameter int TEMP_BITS = rhd_pkg::TEMP_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [rhd_pkg::OP_BITS-1:0]         in_opcode,
  input  wire logic [rhd_pkg::IDX_BITS-1:0]        in_cell_index,
  input  wire logic signed [rhd_pkg::VAL_BITS-1:0] in_cell_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [rhd_pkg::IDX_BITS-1:0]             out_read_index,
  output logic signed [rhd_pkg::VAL_BITS-1:0]      out_temperature,
  output logic                                     out_is_fixed,
  input  wire logic                                cfg_wr_en,
  input  wire logic [rhd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [rhd_pkg::VAL_BITS-1:0]        cfg_wr_data
);

  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int VW = rhd_pkg::VAL_BITS;
  localparam int LW = (TEMP_BITS > VW) ? TEMP_BITS : VW;
  localparam logic signed [LW-1:0] LMAX =
    {{(LW - TEMP_BITS + 1){1'b0}}, {(TEMP_BITS - 1){1'b1}}};
  localparam logic signed [LW-1:0] LMIN = ~LMAX;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_CELLS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_TICK  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_READ  = 5'b10000
  } state_t;

  // saturate a 32-bit value to the stored temperature range
  function automatic logic signed [TEMP_BITS-1:0] sat_val(
    input logic signed [VW-1:0] x
  );
    logic signed [LW-1:0] xe;
    xe = LW'(x);
    if (xe > LMAX) begin
      sat_val = TEMP_BITS'(LMAX);
    end else if (xe < LMIN) begin
      sat_val = TEMP_BITS'(LMIN);
    end else begin
      sat_val = TEMP_BITS'(xe);
    end
  endfunction

  state_t state_r, state_nxt;

  logic [rhd_pkg::GAIN_BITS-1:0]  gain_r;
  logic signed [VW-1:0]           amb_r;
  logic [rhd_pkg::CELLS_BITS-1:0] cells_r;

  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] n_cfg;
  logic [CW-1:0] arr_idx_r, arr_idx_nxt;
  rhd_pkg::beat_t arr_r, arr_nxt;

  logic [rhd_pkg::IDX_BITS-1:0] op_idx_r, op_idx_nxt;
  logic                         oor_r, oor_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [rhd_pkg::IDX_BITS-1:0] out_idx_r, out_idx_nxt;
  logic signed [VW-1:0]         out_temp_r, out_temp_nxt;
  logic                         out_fix_r, out_fix_nxt;

  logic signed [TEMP_BITS-1:0] amb_sat;
  logic signed [TEMP_BITS-1:0] ld_sat;
  logic [TEMP_BITS:0]          ld_wdata;
  logic                        in_accept;
  logic                        in_range;
  logic                        ld_we;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [TEMP_BITS:0]   mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [TEMP_BITS:0]   mem_q;

  logic                 upd_we;
  logic [AW-1:0]        upd_waddr;
  logic [TEMP_BITS:0]   upd_wdata;
  logic                 upd_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= rhd_pkg::GAIN_RESET;
      amb_r   <= rhd_pkg::AMBIENT_RESET;
      cells_r <= rhd_pkg::CELLS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rhd_pkg::CFG_GAIN:    gain_r  <= cfg_wr_data[rhd_pkg::GAIN_BITS-1:0];
        rhd_pkg::CFG_AMBIENT: amb_r   <= signed'(cfg_wr_data);
        rhd_pkg::CFG_CELLS:   cells_r <= cfg_wr_data[rhd_pkg::CELLS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign amb_sat = sat_val(amb_r);
  assign n_cfg   = (32'(cells_r) > 32'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(cells_r);

  // request decode helpers
  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign in_range  = 32'(in_cell_index) < 32'(MAX_CELLS);
  assign ld_sat    = sat_val(in_cell_value);
  assign ld_wdata  = (in_cell_value != '0) ? {1'b1, ld_sat} : {1'b0, amb_sat};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    rd_cnt_nxt    = rd_cnt_r;
    n_nxt         = n_r;
    arr_nxt       = '0;
    arr_idx_nxt   = rd_cnt_r;
    op_idx_nxt    = op_idx_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_temp_nxt  = out_temp_r;
    out_fix_nxt   = out_fix_r;
    ld_we         = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = AW'(in_cell_index);

    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_opcode)
            rhd_pkg::OP_LOAD: ld_we = in_range;
            rhd_pkg::OP_TICK: begin
              if (n_cfg != '0) begin
                n_nxt      = n_cfg;
                rd_cnt_nxt = '0;
                state_nxt  = S_TICK;
              end
            end
            rhd_pkg::OP_READ: begin
              mem_re     = in_range;
              op_idx_nxt = in_cell_index;
              oor_nxt    = !in_range;
              state_nxt  = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_TICK: begin
        // cells 0..n-1, then one beat with ambient on the right
        mem_raddr       = AW'(rd_cnt_r);
        mem_re          = (rd_cnt_r != n_r);
        arr_nxt.vld     = 1'b1;
        arr_nxt.first   = (rd_cnt_r == '0);
        arr_nxt.phantom = (rd_cnt_r == n_r);
        rd_cnt_nxt      = rd_cnt_r + 1'b1;
        if (rd_cnt_r == n_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!arr_r.vld && !upd_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = op_idx_r;
          out_temp_nxt  = oor_r ? VW'(amb_sat) : VW'(signed'(mem_q[TEMP_BITS-1:0]));
          out_fix_nxt   = !oor_r && mem_q[TEMP_BITS];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      arr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      arr_r       <= arr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_cnt_r   <= rd_cnt_nxt;
    n_r        <= n_nxt;
    arr_idx_r  <= arr_idx_nxt;
    op_idx_r   <= op_idx_nxt;
    oor_r      <= oor_nxt;
    out_idx_r  <= out_idx_nxt;
    out_temp_r <= out_temp_nxt;
    out_fix_r  <= out_fix_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_index  = out_idx_r;
  assign out_temperature = out_temp_r;
  assign out_is_fixed    = out_fix_r;

  // memory write arbitration: clearing pass, tick write-back, load
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (upd_we) begin
      mem_we    = 1'b1;
      mem_waddr = upd_waddr;
      mem_wdata = upd_wdata;
    end else begin
      mem_we    = ld_we;
      mem_waddr = AW'(in_cell_index);
      mem_wdata = ld_wdata;
    end
  end

  rhd_cell_mem #(
    .MAX_CELLS (MAX_CELLS),
    .TEMP_BITS (TEMP_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  rhd_update #(
    .MAX_CELLS (MAX_CELLS),
    .TEMP_BITS (TEMP_BITS)
  ) u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat     (arr_r),
    .beat_idx (arr_idx_r),
    .rd_word  (mem_q),
    .amb      (amb_sat),
    .gain     (gain_r),
    .wr_en    (upd_we),
    .wr_addr  (upd_waddr),
    .wr_data  (upd_wdata),
    .busy     (upd_busy)
  );

  // new requests only once the tick pipeline has drained
  a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!upd_busy && !arr_r.vld))
    else $error("request taken while tick write-back pending");

  // a result appears only after a read request
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_READ))
    else $error("result raised outside read");

  // read beat counter stays within the rod
  a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK) |-> (rd_cnt_r <= n_r))
    else $error("tick read counter overran cell count");

  // write-backs only while a tick runs
  a_wb_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    upd_we |-> ((state_r == S_TICK) || (state_r == S_DRAIN)))
    else $error("tick write-back outside tick");

endmodule

`default_nettype wire
